[hdl/lfhr_pkg.sv]
// ----------------------------------------------------------------------------
// lfhr_pkg
// Shared widths, byte codes, phase and kind codes, and the control byte
// matcher for the link frame header receiver.
// ----------------------------------------------------------------------------
package lfhr_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 3;
  localparam int KIND_W     = 3;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [PHASE_W-1:0] phase_t;

  // Line bytes
  localparam byte_t FLAG_BYTE    = 8'h7E;
  localparam byte_t ADDR_TX      = 8'h03;
  localparam byte_t ADDR_RX      = 8'h01;
  localparam byte_t CTL_SET      = 8'h07;
  localparam byte_t CTL_UA       = 8'h03;
  localparam byte_t CTL_DISC     = 8'h0B;
  localparam byte_t CTL_RR_SEQ0  = 8'h21;
  localparam byte_t CTL_RR_SEQ1  = 8'h01;
  localparam byte_t CTL_REJ_SEQ0 = 8'h05;
  localparam byte_t CTL_REJ_SEQ1 = 8'h25;
  localparam byte_t CTL_I_SEQ0   = 8'h00;
  localparam byte_t CTL_I_SEQ1   = 8'h20;

  // Parser phases
  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_FLAG  = 3'd1;
  localparam phase_t PH_ADDR  = 3'd2;
  localparam phase_t PH_CTRL  = 3'd3;
  localparam phase_t PH_CHECK = 3'd4;

  // Frame kinds
  localparam kind_t KIND_NONE = 3'd0;
  localparam kind_t KIND_SET  = 3'd1;
  localparam kind_t KIND_UA   = 3'd2;
  localparam kind_t KIND_DISC = 3'd3;
  localparam kind_t KIND_RR   = 3'd4;
  localparam kind_t KIND_REJ  = 3'd5;
  localparam kind_t KIND_I    = 3'd6;

  // Expected modes
  localparam mode_t MODE_SET    = 3'd0;
  localparam mode_t MODE_UA     = 3'd1;
  localparam mode_t MODE_DISC   = 3'd2;
  localparam mode_t MODE_RR_REJ = 3'd3;
  localparam mode_t MODE_I      = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_FROM_TX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLE_IS_RX    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_BIT  = 2'd3;

  // Configuration reset values
  localparam mode_t RST_EXPECTED_MODE = MODE_SET;
  localparam logic  RST_ADDR_FROM_TX  = 1'b1;
  localparam logic  RST_ROLE_IS_RX    = 1'b1;
  localparam logic  RST_SEQUENCE_BIT  = 1'b1;

  // Kind matched by a control byte under the current mode, or none
  function automatic kind_t match_control(input mode_t mode, input logic seq,
                                          input logic role_rx, input byte_t b);
    kind_t k;
    k = KIND_NONE;
    unique case (mode)
      MODE_SET:  if (b == CTL_SET)  k = KIND_SET;
      MODE_UA:   if (b == CTL_UA)   k = KIND_UA;
      MODE_DISC: if (b == CTL_DISC) k = KIND_DISC;
      MODE_RR_REJ: begin
        if (b == (seq ? CTL_RR_SEQ1 : CTL_RR_SEQ0)) k = KIND_RR;
        else if (b == (seq ? CTL_REJ_SEQ1 : CTL_REJ_SEQ0)) k = KIND_REJ;
      end
      MODE_I: begin
        if (b == (seq ? CTL_I_SEQ1 : CTL_I_SEQ0)) k = KIND_I;
        else if (role_rx && b == CTL_SET) k = KIND_SET;
      end
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[hdl/lfhr_byte_if.sv]
// ----------------------------------------------------------------------------
// lfhr_byte_if
// Valid/ready channel carrying one received line byte per transfer.
// ----------------------------------------------------------------------------
interface lfhr_byte_if;
  import lfhr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/lfhr_result_if.sv]
// ----------------------------------------------------------------------------
// lfhr_result_if
// Valid/ready channel carrying one parse result per transfer.
// ----------------------------------------------------------------------------
interface lfhr_result_if;
  import lfhr_pkg::*;

  logic   valid;
  logic   ready;
  logic   frame_done;
  kind_t  frame_kind;
  phase_t parse_phase;

  modport source (output valid, output frame_done, output frame_kind,
                  output parse_phase, input ready);
  modport sink   (input valid, input frame_done, input frame_kind,
                  input parse_phase, output ready);
endinterface

[hdl/lfhr_cfg_if.sv]
// ----------------------------------------------------------------------------
// lfhr_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lfhr_cfg_if;
  import lfhr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/link_frame_header_receiver_core.sv]
// ----------------------------------------------------------------------------
// link_frame_header_receiver_core
// Parses FLAG, address, control, check, FLAG headers from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries one received line byte per transfer.
//   out_ch  returns exactly one result per accepted byte: frame_done,
//           frame_kind (nonzero only with frame_done) and parse_phase,
//           the parser phase after that byte.
//   cfg_ch  writes the four setup registers (mode, address direction,
//           role, sequence bit); it is always ready. Write it only while
//           no byte is in flight.
// Path: an accepted byte waits in the byte register, is parsed into the
//   result register and can transfer out from there.
// Throughput: one byte per cycle unless out_ch is held; parser state
//   is updated by one compare stage between byte and result registers.
// Reset: the parser returns to idle, both pipeline registers empty, and
//   the setup registers take their defaults (SET mode, transmitter
//   address, receiver role, sequence bit 1).
// Stall: while out_ch is held, the result register holds; one more byte
//   is still taken into the byte register before in_ch.ready drops.
// ----------------------------------------------------------------------------
module link_frame_header_receiver_core (
  input  logic                 clk,
  input  logic                 rst_n,
  lfhr_byte_if.sink            in_ch,
  lfhr_result_if.source        out_ch,
  lfhr_cfg_if.sink             cfg_ch
);
  import lfhr_pkg::*;

  // Setup registers
  mode_t  mode_r;
  logic   addr_from_tx_r;
  logic   role_rx_r;
  logic   seq_bit_r;

  // Byte register
  logic   byte_vld_r;
  byte_t  byte_r;

  // Parser state
  phase_t phase_r, phase_nxt;
  kind_t  kind_seen_r, kind_seen_nxt;
  byte_t  ctl_seen_r, ctl_seen_nxt;

  // Result register
  logic   out_vld_r;
  logic   out_done_r, out_done_nxt;
  kind_t  out_kind_r, out_kind_nxt;
  phase_t out_phase_r;

  logic   advance;
  logic   in_xfer;
  phase_t phase_cur;
  byte_t  want_addr;
  kind_t  ctl_kind;

  // Handshake
  assign advance      = byte_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !byte_vld_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.frame_done  = out_done_r;
  assign out_ch.frame_kind  = out_kind_r;
  assign out_ch.parse_phase = out_phase_r;

  // Setup register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= RST_EXPECTED_MODE;
      addr_from_tx_r <= RST_ADDR_FROM_TX;
      role_rx_r      <= RST_ROLE_IS_RX;
      seq_bit_r      <= RST_SEQUENCE_BIT;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_EXPECTED_MODE: mode_r         <= cfg_ch.data[MODE_W-1:0];
        REG_ADDR_FROM_TX:  addr_from_tx_r <= cfg_ch.data[0];
        REG_ROLE_IS_RX:    role_rx_r      <= cfg_ch.data[0];
        REG_SEQUENCE_BIT:  seq_bit_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Byte register: load on input transfer, drain on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_xfer) begin
      byte_vld_r <= 1'b1;
    end else if (advance) begin
      byte_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  // Parse one byte
  assign phase_cur = (phase_r > PH_CHECK) ? PH_IDLE : phase_r;
  assign want_addr = addr_from_tx_r ? ADDR_TX : ADDR_RX;
  assign ctl_kind  = match_control(mode_r, seq_bit_r, role_rx_r, byte_r);

  always_comb begin
    phase_nxt     = phase_cur;
    kind_seen_nxt = kind_seen_r;
    ctl_seen_nxt  = ctl_seen_r;
    out_done_nxt  = 1'b0;
    out_kind_nxt  = KIND_NONE;
    if (phase_cur < PH_CHECK && byte_r == FLAG_BYTE) begin
      // restart header on any flag before the check byte
      phase_nxt = PH_FLAG;
    end else begin
      unique case (phase_cur)
        PH_FLAG: begin
          if (byte_r == want_addr) begin
            phase_nxt = PH_ADDR;
          end else begin
            phase_nxt     = PH_IDLE;
            kind_seen_nxt = KIND_NONE;
            ctl_seen_nxt  = '0;
          end
        end
        PH_ADDR: begin
          if (ctl_kind != KIND_NONE) begin
            phase_nxt     = PH_CTRL;
            kind_seen_nxt = ctl_kind;
            ctl_seen_nxt  = byte_r;
          end else begin
            phase_nxt     = PH_IDLE;
            kind_seen_nxt = KIND_NONE;
            ctl_seen_nxt  = '0;
          end
        end
        PH_CTRL: begin
          if (byte_r == (want_addr ^ ctl_seen_r)) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt     = PH_IDLE;
            kind_seen_nxt = KIND_NONE;
            ctl_seen_nxt  = '0;
          end
        end
        PH_CHECK: begin
          // closing flag reports the frame; anything else drops it
          if (byte_r == FLAG_BYTE) begin
            out_done_nxt = 1'b1;
            out_kind_nxt = kind_seen_r;
          end
          phase_nxt     = PH_IDLE;
          kind_seen_nxt = KIND_NONE;
          ctl_seen_nxt  = '0;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Parser state advances once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      kind_seen_r <= KIND_NONE;
      ctl_seen_r  <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      kind_seen_r <= kind_seen_nxt;
      ctl_seen_r  <= ctl_seen_nxt;
    end
  end

  // Result register: load on advance, release on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_done_r  <= out_done_nxt;
      out_kind_r  <= out_kind_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  // Checks
  a_kind_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_done_r |-> out_kind_r == KIND_NONE)
    else $error("frame kind reported without a closed frame");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_done_r |-> out_phase_r == PH_IDLE && out_kind_r != KIND_NONE)
    else $error("closed frame did not return parser to idle with a kind");

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CHECK)
    else $error("parser phase out of range");

  a_check_phase_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == PH_CHECK |=> phase_r == PH_IDLE)
    else $error("parser stayed past the check phase");

  a_byte_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !advance |=> byte_vld_r && $stable(byte_r))
    else $error("pending byte lost while the result register was full");

endmodule
